@@ rtl/core/aes_sbox_pkg.sv @@
package aes_sbox_pkg;

    // Command codes carried in the cmd field of an input word.
    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_INV = 1'b1;

    // Field and affine constants.
    localparam logic [7:0] AFFINE_CONST     = 8'h63;
    localparam logic [7:0] INV_AFFINE_CONST = 8'h05;
    // Low byte of x^8+x^4+x^3+x+1, folded back in when x^8 appears.
    localparam logic [7:0] POLY_REDUCE      = 8'h1B;

    // Number of register stages from input to output.
    localparam int unsigned STAGES = 5;

    typedef logic [7:0] gf_byte_t;

    // Multiply two field elements: shift-and-add with reduction.
    function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
        gf_byte_t x;
        gf_byte_t acc;
        begin
            x   = a;
            acc = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (b[i])
                begin
                    acc = acc ^ x;
                end
                x = {x[6:0], 1'b0} ^ (x[7] ? POLY_REDUCE : 8'h00);
            end
            return acc;
        end
    endfunction

    // Squaring is linear over the field: the bits move to the even positions
    // and the high part is reduced, which leaves only a few XORs.
    function automatic gf_byte_t gf_sq(input gf_byte_t a);
        logic [14:0] wide;
        begin
            wide = '0;
            for (int i = 0; i < 8; i++)
            begin
                wide[2 * i] = a[i];
            end
            for (int k = 14; k >= 8; k--)
            begin
                if (wide[k])
                begin
                    wide = wide ^ ({6'b0, 1'b1, POLY_REDUCE} << (k - 8));
                end
            end
            return wide[7:0];
        end
    endfunction

    // Forward affine transform: b ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ 0x63.
    function automatic gf_byte_t affine_fwd(input gf_byte_t b);
        return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                 ^ {b[3:0], b[7:4]} ^ AFFINE_CONST;
    endfunction

    // Inverse affine transform: rotl1 ^ rotl3 ^ rotl6 ^ 0x05.
    function automatic gf_byte_t affine_inv(input gf_byte_t s);
        return {s[6:0], s[7]} ^ {s[4:0], s[7:5]} ^ {s[1:0], s[7:2]} ^ INV_AFFINE_CONST;
    endfunction

endpackage

@@ rtl/core/aes_sbox_in_if.sv @@
interface aes_sbox_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] byte_in;

    modport source (output valid, output cmd, output byte_in, input ready);
    modport sink (input valid, input cmd, input byte_in, output ready);
endinterface

@@ rtl/core/aes_sbox_out_if.sv @@
interface aes_sbox_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;

    modport source (output valid, output byte_out, input ready);
    modport sink (input valid, input byte_out, output ready);
endinterface

@@ rtl/core/aes_sbox_compute_unit.sv @@
// AES S-box, computed in the field rather than read from a table. Each input
// word gives a byte and a direction (cmd 0 forward, 1 inverse); one output word
// with the substituted byte comes back per input, in order. The unit accepts
// one word per clock unless stalled. The accepting edge loads the first of five
// register stages; the word moves to the output register, offered from then on.
// The stages take the inverse affine step (cmd 1), then compute x^254 through
// the chain x^3, x^15, x^252, x^254 with one field multiply in each of the last
// four stages, the last also applying the forward affine step (cmd 0). Output
// back-pressure stalls the pipeline in place; empty stages still fill, so
// nothing is lost or repeated. Reset only clears the stage valid bits.
module aes_sbox_compute_unit
(
    input  logic            clk,
    input  logic            rst_n,
    aes_sbox_in_if.sink     sub_in,
    aes_sbox_out_if.source  sub_out
);

    localparam int unsigned LAST = aes_sbox_pkg::STAGES - 1;

    // Stage valid bits and load enables.
    logic v_reg [aes_sbox_pkg::STAGES];
    logic v_next [aes_sbox_pkg::STAGES];
    logic rdy [aes_sbox_pkg::STAGES + 1];

    // Stage 0: field operand after the optional inverse affine step.
    logic                    cmd0_reg;
    aes_sbox_pkg::gf_byte_t  x0_reg;
    // Stage 1: x^2 and x^3.
    logic                    cmd1_reg;
    aes_sbox_pkg::gf_byte_t  x2_1_reg;
    aes_sbox_pkg::gf_byte_t  x3_reg;
    // Stage 2: x^2, x^12 and x^15.
    logic                    cmd2_reg;
    aes_sbox_pkg::gf_byte_t  x2_2_reg;
    aes_sbox_pkg::gf_byte_t  x12_reg;
    aes_sbox_pkg::gf_byte_t  x15_reg;
    // Stage 3: x^2 and x^252.
    logic                    cmd3_reg;
    aes_sbox_pkg::gf_byte_t  x2_3_reg;
    aes_sbox_pkg::gf_byte_t  x252_reg;
    // Stage 4: finished byte.
    aes_sbox_pkg::gf_byte_t  out_reg;

    aes_sbox_pkg::gf_byte_t  x0_next;
    aes_sbox_pkg::gf_byte_t  x2_1_next;
    aes_sbox_pkg::gf_byte_t  x3_next;
    aes_sbox_pkg::gf_byte_t  x12_next;
    aes_sbox_pkg::gf_byte_t  x15_next;
    aes_sbox_pkg::gf_byte_t  x252_next;
    aes_sbox_pkg::gf_byte_t  x254;
    aes_sbox_pkg::gf_byte_t  out_next;

    // A stage loads when it is empty or its word moves on this cycle.
    always_comb
    begin
        rdy[aes_sbox_pkg::STAGES] = sub_out.ready;
        for (int i = LAST; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i + 1];
        end
        v_next[0] = rdy[0] ? sub_in.valid : v_reg[0];
        for (int i = 1; i < aes_sbox_pkg::STAGES; i++)
        begin
            v_next[i] = rdy[i] ? v_reg[i - 1] : v_reg[i];
        end
    end

    assign sub_in.ready  = rdy[0];
    assign sub_out.valid = v_reg[LAST];
    assign sub_out.byte_out = out_reg;

    // Datapath for each stage: one field multiply at most.
    always_comb
    begin
        x0_next   = (sub_in.cmd == aes_sbox_pkg::CMD_INV)
                    ? aes_sbox_pkg::affine_inv(sub_in.byte_in) : sub_in.byte_in;
        x2_1_next = aes_sbox_pkg::gf_sq(x0_reg);
        x3_next   = aes_sbox_pkg::gf_mul(x2_1_next, x0_reg);
        x12_next  = aes_sbox_pkg::gf_sq(aes_sbox_pkg::gf_sq(x3_reg));
        x15_next  = aes_sbox_pkg::gf_mul(x12_next, x3_reg);
        x252_next = aes_sbox_pkg::gf_mul(
                        aes_sbox_pkg::gf_sq(aes_sbox_pkg::gf_sq(
                        aes_sbox_pkg::gf_sq(aes_sbox_pkg::gf_sq(x15_reg)))),
                        x12_reg);
        x254      = aes_sbox_pkg::gf_mul(x252_reg, x2_3_reg);
        out_next  = (cmd3_reg == aes_sbox_pkg::CMD_FWD)
                    ? aes_sbox_pkg::affine_fwd(x254) : x254;
    end

    // Valid bits reset; payload registers do not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aes_sbox_pkg::STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < aes_sbox_pkg::STAGES; i++)
            begin
                v_reg[i] <= v_next[i];
            end
        end
    end

    // Payload registers advance with their stage.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            cmd0_reg <= sub_in.cmd;
            x0_reg   <= x0_next;
        end
        if (rdy[1])
        begin
            cmd1_reg <= cmd0_reg;
            x2_1_reg <= x2_1_next;
            x3_reg   <= x3_next;
        end
        if (rdy[2])
        begin
            cmd2_reg <= cmd1_reg;
            x2_2_reg <= x2_1_reg;
            x12_reg  <= x12_next;
            x15_reg  <= x15_next;
        end
        if (rdy[3])
        begin
            cmd3_reg <= cmd2_reg;
            x2_3_reg <= x2_2_reg;
            x252_reg <= x252_next;
        end
        if (rdy[4])
        begin
            out_reg <= out_next;
        end
    end

    // The input is held off only when every stage is full and the output stalls.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !sub_in.ready |-> (v_reg[0] && v_reg[1] && v_reg[2] && v_reg[3] && v_reg[4]
                           && !sub_out.ready))
        else $error("input blocked while a stage is free");

    // An accepted word lands in the first stage.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (sub_in.valid && sub_in.ready) |=> v_reg[0])
        else $error("accepted word did not enter the pipeline");

    // A stalled middle stage keeps its word.
    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && !rdy[3]) |=> (v_reg[2] && $stable(x15_reg) && $stable(x12_reg)))
        else $error("stalled stage lost its word");

    // The output register holds its word until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST] && !sub_out.ready) |=> (v_reg[LAST] && $stable(out_reg)))
        else $error("stalled output word changed");

endmodule

@@ tb/tb_aes_sbox_compute_unit.sv @@
`timescale 1ns / 1ps

module tb_aes_sbox_compute_unit;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = aes_sbox_pkg::STAGES * 4;
    localparam int unsigned MAX_REPORTS = 10;

    logic clk;
    logic rst_n;

    aes_sbox_in_if  sub_in();
    aes_sbox_out_if sub_out();

    aes_sbox_compute_unit u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .sub_in  (sub_in),
        .sub_out (sub_out)
    );

    // Substitution tables built independently at time zero.
    aes_sbox_pkg::gf_byte_t fwd_sbox [256];
    aes_sbox_pkg::gf_byte_t inv_sbox [256];

    aes_sbox_pkg::gf_byte_t expected_bytes [$];
    aes_sbox_pkg::gf_byte_t expected_head;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Carry-less product of two bytes, reduced from the top bit down.
    function automatic aes_sbox_pkg::gf_byte_t field_product(
        input aes_sbox_pkg::gf_byte_t a, input aes_sbox_pkg::gf_byte_t b);
        logic [14:0] wide;
        wide = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                wide = wide ^ (15'(a) << k);
            end
        end
        for (int k = 14; k >= 8; k--)
        begin
            if (wide[k])
            begin
                wide = wide ^ (15'h11B << (k - 8));
            end
        end
        return wide[7:0];
    endfunction

    // Forward table: reciprocal by search, then the affine map bit by bit.
    // The inverse table is the forward table read backwards.
    initial
    begin
        aes_sbox_pkg::gf_byte_t recip;
        aes_sbox_pkg::gf_byte_t mapped;
        for (int a = 0; a < 256; a++)
        begin
            recip = 8'h00;
            for (int x = 1; x < 256; x++)
            begin
                if (a != 0 && field_product(8'(a), 8'(x)) == 8'h01)
                begin
                    recip = 8'(x);
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                mapped[i] = recip[i] ^ recip[(i + 4) % 8] ^ recip[(i + 5) % 8]
                          ^ recip[(i + 6) % 8] ^ recip[(i + 7) % 8]
                          ^ aes_sbox_pkg::AFFINE_CONST[i];
            end
            fwd_sbox[a] = mapped;
            inv_sbox[mapped] = 8'(a);
        end
    end

    // Initial values on the source side; the sink ready comes from reset.
    initial
    begin
        rst_n          <= 1'b0;
        sub_in.valid   <= 1'b0;
        sub_in.cmd     <= aes_sbox_pkg::CMD_FWD;
        sub_in.byte_in <= 8'h00;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        error_count    = 0;
        cycle_count    = 0;
    end

    // Output back-pressure, random at the current stall rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_out.ready <= 1'b0;
        end
        else
        begin
            sub_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted output word with the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && sub_out.valid === 1'b1 && sub_out.ready === 1'b1)
        begin
            if (expected_bytes.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("unexpected output word: byte_out=%02h", sub_out.byte_out);
                end
            end
            else
            begin
                expected_head = expected_bytes.pop_front();
                if (sub_out.byte_out !== expected_head)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("byte_out mismatch: expected %02h, actual %02h",
                                 expected_head, sub_out.byte_out);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one word after a random gap and hold it until it is taken.
    task automatic send_word(input logic op, input aes_sbox_pkg::gf_byte_t value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sub_in.valid   <= 1'b0;
            sub_in.byte_in <= 8'($urandom_range(255));
            @(posedge clk);
        end
        sub_in.valid   <= 1'b1;
        sub_in.cmd     <= op;
        sub_in.byte_in <= value;
        do
        begin
            @(posedge clk);
        end
        while (sub_in.ready !== 1'b1);
        expected_bytes.push_back((op == aes_sbox_pkg::CMD_FWD)
                                 ? fwd_sbox[value] : inv_sbox[value]);
    endtask

    // Stop offering words and wait for every expected byte to come back.
    task automatic settle_pipeline();
        sub_in.valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_bytes(input int unsigned count);
        for (int n = 0; n < count; n++)
        begin
            send_word($urandom_range(1) ? aes_sbox_pkg::CMD_INV : aes_sbox_pkg::CMD_FWD,
                      8'($urandom_range(255)));
        end
        settle_pipeline();
    endtask

    // Zero in both directions, the all-ones byte, single-bit bytes and
    // bytes that map to or from zero.
    task automatic test_corner_bytes();
        send_word(aes_sbox_pkg::CMD_FWD, 8'h00);
        send_word(aes_sbox_pkg::CMD_INV, 8'h00);
        send_word(aes_sbox_pkg::CMD_FWD, 8'hFF);
        send_word(aes_sbox_pkg::CMD_INV, 8'hFF);
        send_word(aes_sbox_pkg::CMD_FWD, 8'h01);
        send_word(aes_sbox_pkg::CMD_INV, 8'h01);
        send_word(aes_sbox_pkg::CMD_FWD, 8'h80);
        send_word(aes_sbox_pkg::CMD_INV, 8'h80);
        send_word(aes_sbox_pkg::CMD_INV, 8'h63);
        send_word(aes_sbox_pkg::CMD_FWD, 8'h63);
        send_word(aes_sbox_pkg::CMD_INV, 8'h7C);
        send_word(aes_sbox_pkg::CMD_FWD, 8'h52);
        send_word(aes_sbox_pkg::CMD_INV, 8'h52);
        send_word(aes_sbox_pkg::CMD_FWD, 8'hAA);
        send_word(aes_sbox_pkg::CMD_INV, 8'h55);
        send_word(aes_sbox_pkg::CMD_FWD, 8'h0F);
        send_word(aes_sbox_pkg::CMD_INV, 8'hF0);
        send_word(aes_sbox_pkg::CMD_FWD, 8'h02);
        send_word(aes_sbox_pkg::CMD_INV, 8'h16);
        send_word(aes_sbox_pkg::CMD_FWD, 8'h00);
        settle_pipeline();
    endtask

    // Light source gaps against a heavily stalled sink.
    task automatic test_slow_sink();
        send_idle_pct = 22;
        recv_idle_pct = 82;
        random_bytes(280);
    endtask

    // Heavy source gaps against a mostly ready sink.
    task automatic test_slow_source();
        send_idle_pct = 82;
        recv_idle_pct = 22;
        random_bytes(280);
    endtask

    // Back-to-back words at full rate on both sides.
    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_bytes(290);
    endtask

    // Test sequence.
    initial
    begin
        repeat (2)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 82;
        test_corner_bytes();
        test_slow_sink();
        test_slow_source();
        test_full_rate();

        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (error_count == 0 && expected_bytes.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/aes_sbox_pkg.sv
rtl/core/aes_sbox_in_if.sv
rtl/core/aes_sbox_out_if.sv
rtl/core/aes_sbox_compute_unit.sv
tb/tb_aes_sbox_compute_unit.sv
